// ----- sv/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr_pkg: shared types and constants for the linear fade ramp
// Request and response payloads, action codes, divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package lfr_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LEVEL_W   = FRAC_BITS + 1;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned DIV_CNT_W = $clog2(LEVEL_W + 1);

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1) << FRAC_BITS;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

  typedef enum logic [1:0] {
    ACT_SET  = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [LEVEL_W-1:0] level_value;
    logic               to_dark;
    logic [COUNT_W-1:0] frame_count;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] frames_left;
    logic               finished;
  } rsp_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_status_t;

endpackage

`default_nettype wire

// ----- sv/linear_fade_ramp_core.sv -----
// ----------------------------------------------------------------------------
// linear_fade_ramp_core: linear brightness fade over a number of frames
// Set level, load fade job, frame tick; step found by serial division.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   in_req_i   (lfr_pkg::req_t)
//   out      out  out_valid_o/out_ready_i out_rsp_o  (lfr_pkg::rsp_t)
//
// Set, load, later ticks: result registered one cycle after acceptance.
// First tick of a job: waits in ST_DIV for the serial divider; result registered when its done is seen.
// Reset: level 1.0, no job, nothing pending.
// A new request is taken while idle and the output register is free or
// being emptied in the same cycle; out_ready_i low holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_fade_ramp_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire lfr_pkg::req_t in_req_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output lfr_pkg::rsp_t out_rsp_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_e;

  state_e                      state_q;
  logic [lfr_pkg::LEVEL_W-1:0] level_q;
  logic [lfr_pkg::COUNT_W-1:0] rem_q;
  logic                        started_q;
  logic [lfr_pkg::LEVEL_W-1:0] step_q;
  logic                        dir_q;
  lfr_pkg::rsp_t               out_q;
  logic                        out_valid_q;

  lfr_pkg::div_status_t        div_st;
  logic                        accept;
  logic                        div_start;
  logic                        out_fire;
  logic [lfr_pkg::LEVEL_W-1:0] span;
  logic [lfr_pkg::LEVEL_W-1:0] set_level;
  logic [lfr_pkg::LEVEL_W-1:0] step_s;
  logic [lfr_pkg::LEVEL_W:0]   lvl_sum;
  logic [lfr_pkg::LEVEL_W-1:0] tick_level;
  logic [lfr_pkg::COUNT_W-1:0] tick_rem;
  logic                        tick_done;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign div_start  = accept && (in_req_i.action == lfr_pkg::ACT_TICK) &&
                      (rem_q != '0) && !started_q;
  assign out_fire   = (accept && !div_start) || ((state_q == ST_DIV) && div_st.done);

  always_comb begin
    if (!dir_q) begin
      span = (level_q < lfr_pkg::LEVEL_ONE) ? (lfr_pkg::LEVEL_ONE - level_q)
                                            : lfr_pkg::LEVEL_ONE;
    end else begin
      span = (level_q != lfr_pkg::LEVEL_ZERO) ? level_q : lfr_pkg::LEVEL_ONE;
    end
    set_level = (in_req_i.level_value > lfr_pkg::LEVEL_ONE) ? lfr_pkg::LEVEL_ONE
                                                             : in_req_i.level_value;
  end

  // one tick applied with the current step (fresh quotient on the first tick)
  always_comb begin
    step_s     = (state_q == ST_DIV) ? div_st.quotient : step_q;
    lvl_sum    = {1'b0, level_q} + {1'b0, step_s};
    tick_level = level_q;
    if (!dir_q) begin
      if (level_q < lfr_pkg::LEVEL_ONE) begin
        tick_level = (lvl_sum > {1'b0, lfr_pkg::LEVEL_ONE}) ? lfr_pkg::LEVEL_ONE
                                                            : lvl_sum[lfr_pkg::LEVEL_W-1:0];
      end
    end else if (level_q != lfr_pkg::LEVEL_ZERO) begin
      tick_level = (level_q > step_s) ? (level_q - step_s) : lfr_pkg::LEVEL_ZERO;
    end
    tick_rem  = rem_q - 1'b1;
    tick_done = (tick_rem == '0);
    if (tick_done) begin
      tick_level = dir_q ? lfr_pkg::LEVEL_ZERO : lfr_pkg::LEVEL_ONE;
    end
  end

  lfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (span),
    .divisor_i  (rem_q),
    .status_o   (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= lfr_pkg::LEVEL_ONE;
      rem_q       <= '0;
      started_q   <= 1'b0;
      step_q      <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req_i.action)
              lfr_pkg::ACT_SET: begin
                level_q     <= set_level;
                out_q       <= '{level: set_level, frames_left: rem_q, finished: 1'b0};
                out_valid_q <= 1'b1;
              end
              lfr_pkg::ACT_LOAD: begin
                dir_q       <= in_req_i.to_dark;
                rem_q       <= in_req_i.frame_count;
                started_q   <= 1'b0;
                out_q       <= '{level: level_q, frames_left: in_req_i.frame_count,
                                 finished: 1'b0};
                out_valid_q <= 1'b1;
              end
              lfr_pkg::ACT_TICK: begin
                if (rem_q == '0) begin
                  out_q       <= '{level: level_q, frames_left: rem_q, finished: 1'b0};
                  out_valid_q <= 1'b1;
                end else if (!started_q) begin
                  state_q <= ST_DIV;
                end else begin
                  level_q     <= tick_level;
                  rem_q       <= tick_rem;
                  out_q       <= '{level: tick_level, frames_left: tick_rem,
                                   finished: tick_done};
                  out_valid_q <= 1'b1;
                end
              end
              default: begin
                out_q       <= '{level: level_q, frames_left: rem_q, finished: 1'b0};
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            step_q      <= div_st.quotient;
            started_q   <= 1'b1;
            level_q     <= tick_level;
            rem_q       <= tick_rem;
            out_q       <= '{level: tick_level, frames_left: tick_rem, finished: tick_done};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= lfr_pkg::LEVEL_ONE)
    else $error("level above full scale");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == ST_DIV)
    else $error("divider finished outside division state");

  a_no_out_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> !out_valid_q)
    else $error("result pending during division");

  a_finished_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.finished |-> out_q.frames_left == '0)
    else $error("finished with frames left");

  a_start_sets_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && div_st.done |=> started_q && state_q == ST_IDLE)
    else $error("job not marked started after division");

endmodule

`default_nettype wire

// ----- sv/lfr_div.sv -----
// ----------------------------------------------------------------------------
// lfr_div: restoring serial divider
// One quotient bit per cycle; done pulses for one cycle with the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lfr_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [lfr_pkg::LEVEL_W-1:0]    dividend_i,
  input  wire logic [lfr_pkg::COUNT_W-1:0]    divisor_i,
  output lfr_pkg::div_status_t                status_o
);

  logic [lfr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [lfr_pkg::LEVEL_W-1:0]   quo_q;
  logic [lfr_pkg::COUNT_W-1:0]   rem_q;
  logic [lfr_pkg::COUNT_W-1:0]   dvs_q;
  logic                          busy_q;
  logic                          done_q;

  logic [lfr_pkg::COUNT_W:0]     trial;
  logic [lfr_pkg::COUNT_W:0]     diff;
  logic                          ge;

  always_comb begin
    trial = {rem_q, quo_q[lfr_pkg::LEVEL_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    diff  = trial - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      quo_q  <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      cnt_q  <= lfr_pkg::DIV_CNT_W'(lfr_pkg::LEVEL_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[lfr_pkg::COUNT_W-1:0] : trial[lfr_pkg::COUNT_W-1:0];
      quo_q <= {quo_q[lfr_pkg::LEVEL_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == lfr_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign status_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for linear_fade_ramp_core
// Drives set, load and frame-tick requests through the valid/ready channels.
// A directed opening covers the field extremes and the corner cases of the
// fade. Random fade jobs and noise follow under several idling and stall
// patterns. Each response is compared field by field with a software
// tracker of the fade state.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  class fade_level_tracker;
    logic [lfr_pkg::LEVEL_W-1:0] level;
    logic [lfr_pkg::COUNT_W-1:0] frames;
    logic                        started;
    logic [lfr_pkg::LEVEL_W-1:0] step;
    logic                        dir_out;
    lfr_pkg::rsp_t               expected_levels[$];
    int unsigned                 mismatches;
    int unsigned                 responses;
    int unsigned                 fades_done;

    function new();
      level      = lfr_pkg::LEVEL_ONE;
      frames     = '0;
      started    = 1'b0;
      step       = '0;
      dir_out    = 1'b0;
      mismatches = 0;
      responses  = 0;
      fades_done = 0;
    endfunction

    function void note_request(lfr_pkg::req_t r);
      lfr_pkg::rsp_t               e;
      logic [lfr_pkg::LEVEL_W:0]   sum;
      logic [lfr_pkg::LEVEL_W-1:0] span;
      e.finished = 1'b0;
      case (r.action)
        lfr_pkg::ACT_SET: begin
          level = (r.level_value > lfr_pkg::LEVEL_ONE) ? lfr_pkg::LEVEL_ONE
                                                       : r.level_value;
        end
        lfr_pkg::ACT_LOAD: begin
          dir_out = r.to_dark;
          frames  = r.frame_count;
          started = 1'b0;
        end
        lfr_pkg::ACT_TICK: begin
          if (frames != '0) begin
            if (!started) begin
              // zero distance counts as a full swing
              if (!dir_out) span = (level < lfr_pkg::LEVEL_ONE) ?
                                   lfr_pkg::LEVEL_ONE - level : lfr_pkg::LEVEL_ONE;
              else span = (level != lfr_pkg::LEVEL_ZERO) ? level : lfr_pkg::LEVEL_ONE;
              step    = span / frames;
              started = 1'b1;
            end
            if (!dir_out) begin
              if (level < lfr_pkg::LEVEL_ONE) begin
                sum   = {1'b0, level} + step;
                level = (sum > lfr_pkg::LEVEL_ONE) ? lfr_pkg::LEVEL_ONE
                                                   : sum[lfr_pkg::LEVEL_W-1:0];
              end
            end else begin
              level = (level > step) ? level - step : lfr_pkg::LEVEL_ZERO;
            end
            frames = frames - 1'b1;
            if (frames == '0) begin
              level      = dir_out ? lfr_pkg::LEVEL_ZERO : lfr_pkg::LEVEL_ONE;
              e.finished = 1'b1;
              fades_done++;
            end
          end
        end
        default: ;
      endcase
      e.level       = level;
      e.frames_left = frames;
      expected_levels.push_back(e);
    endfunction

    function void check_response(lfr_pkg::rsp_t got);
      lfr_pkg::rsp_t e;
      responses++;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected response level %0d frames_left %0d finished %0d",
                 $time, got.level, got.frames_left, got.finished);
        mismatches++;
        return;
      end
      e = expected_levels.pop_front();
      if (got.level !== e.level) begin
        $display("%0t: level expected %0d got %0d", $time, e.level, got.level);
        mismatches++;
      end
      if (got.frames_left !== e.frames_left) begin
        $display("%0t: frames_left expected %0d got %0d", $time, e.frames_left,
                 got.frames_left);
        mismatches++;
      end
      if (got.finished !== e.finished) begin
        $display("%0t: finished expected %0d got %0d", $time, e.finished, got.finished);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_levels.size();
    endfunction
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  lfr_pkg::req_t in_req_i    = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  lfr_pkg::rsp_t out_rsp_o;

  fade_level_tracker tracker;
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct     = 0;
  bit                long_hold_req = 1'b0;
  int unsigned       hold_left     = 0;
  int unsigned       sent          = 0;
  int unsigned       ignored       = 0;

  linear_fade_ramp_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = HOLD_CYCLES;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_response(out_rsp_o);
  end

  function automatic lfr_pkg::req_t make_req(logic [1:0] action,
                                             logic [lfr_pkg::LEVEL_W-1:0] value,
                                             logic dir,
                                             logic [lfr_pkg::COUNT_W-1:0] count);
    lfr_pkg::req_t r;
    r.action      = action;
    r.level_value = value;
    r.to_dark     = dir;
    r.frame_count = count;
    return r;
  endfunction

  function automatic logic [lfr_pkg::LEVEL_W-1:0] pick_level();
    case ($urandom_range(9))
      0: return lfr_pkg::LEVEL_ZERO;
      1: return lfr_pkg::LEVEL_ONE;
      2: return lfr_pkg::LEVEL_W'($urandom_range(131071, 65537));
      3: return lfr_pkg::LEVEL_W'($urandom_range(15));
      default: return lfr_pkg::LEVEL_W'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [lfr_pkg::COUNT_W-1:0] pick_count();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return lfr_pkg::COUNT_W'($urandom_range(12, 1));
    if (p < 90) return lfr_pkg::COUNT_W'($urandom_range(300, 13));
    if (p < 95) return '0;
    return lfr_pkg::COUNT_W'($urandom);
  endfunction

  task automatic send_req(lfr_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_request(r);
    if (r.action == ACT_UNUSED) ignored++;
    else sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_burst();
    logic [lfr_pkg::COUNT_W-1:0] cnt;
    int unsigned                 n_ticks;
    int unsigned                 i;
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(1))
        send_req(make_req(lfr_pkg::ACT_SET, pick_level(), 1'($urandom),
                          lfr_pkg::COUNT_W'($urandom)));
      cnt = pick_count();
      send_req(make_req(lfr_pkg::ACT_LOAD, lfr_pkg::LEVEL_W'($urandom), 1'($urandom), cnt));
      n_ticks = (cnt > 16) ? $urandom_range(16, 1) : cnt + $urandom_range(2);
      for (i = 0; i < n_ticks; i++) begin
        if ($urandom_range(99) < 5)
          send_req(make_req(lfr_pkg::ACT_SET, pick_level(), 1'($urandom),
                            lfr_pkg::COUNT_W'($urandom)));
        send_req(make_req(lfr_pkg::ACT_TICK, lfr_pkg::LEVEL_W'($urandom), 1'($urandom),
                          lfr_pkg::COUNT_W'($urandom)));
      end
    end else begin
      send_req(make_req(2'($urandom_range(3)), lfr_pkg::LEVEL_W'($urandom_range(131071)),
                        1'($urandom), lfr_pkg::COUNT_W'($urandom)));
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned goal;
    int unsigned i;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // opening: field extremes and corner cases
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_SET, lfr_pkg::LEVEL_ZERO, 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_SET, '1, 1'b1, '1));
    send_req(make_req(ACT_UNUSED, '1, 1'b1, '1));
    send_req(make_req(lfr_pkg::ACT_LOAD, '0, 1'b1, 16'd4));
    for (i = 0; i < 4; i++) send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    // fade out from dark: full swing, level already at the end value
    send_req(make_req(lfr_pkg::ACT_LOAD, '0, 1'b1, 16'd3));
    for (i = 0; i < 3; i++) send_req(make_req(lfr_pkg::ACT_TICK, '1, 1'b1, '1));
    send_req(make_req(lfr_pkg::ACT_LOAD, '0, 1'b0, '1));
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    // distance smaller than the count
    send_req(make_req(lfr_pkg::ACT_SET, lfr_pkg::LEVEL_W'(65530), 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_LOAD, '0, 1'b0, 16'd100));
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_LOAD, '0, 1'b0, 16'd1));
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b0, '0));
    send_req(make_req(lfr_pkg::ACT_LOAD, '1, 1'b1, '0));
    send_req(make_req(lfr_pkg::ACT_TICK, '0, 1'b1, '0));
    send_req(make_req(lfr_pkg::ACT_SET, lfr_pkg::LEVEL_ONE, 1'b0, '0));
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      goal = sent + ITEMS_PER_PHASE;
      while (sent < goal) run_random_burst();
      if (phase == 0) begin
        // long receiver hold-off while requests keep coming
        long_hold_req = 1'b1;
        for (i = 0; i < 12; i++) run_random_burst();
      end
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (25) @(posedge clk_i);
    $display("Run covered %0d requests plus %0d unused action codes, %0d responses checked,",
             sent, ignored, tracker.responses);
    $display("%0d fades run to completion, four idle/stall patterns and a long output hold.",
             tracker.fades_done);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
